// ===== rtl/rtn_pkg.sv =====
//------------------------------------------------------------------------------
// rtn_pkg: shared types and constants for the ray-triangle nearest-hit unit
// Holds the fixed widths, register indexes, queue depth, determinant threshold
// and the state type of the divide and compare back.
//------------------------------------------------------------------------------
package rtn_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FACE_BITS_DEF  = 20;
  localparam int DIST_BITS      = 32;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int PROD_BITS      = 128;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [PROD_BITS-1:0] DET_EPS = PROD_BITS'(68719477);

  localparam logic [CFG_ADDR_BITS-1:0] REG_ORG_X = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORG_Y = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORG_Z = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIR_Z = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAXD  = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CULL  = 3'd7;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

// ===== rtl/rtn_front.sv =====
//------------------------------------------------------------------------------
// rtn_front: intersection front end
// Computes edges, cross and dot products over a pipeline with one multiply
// level per stage, and classifies each triangle as a candidate or a miss.
//------------------------------------------------------------------------------
module rtn_front #(
  parameter int COORD_BITS = rtn_pkg::COORD_BITS_DEF,
  parameter int FACE_BITS  = rtn_pkg::FACE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          vtx [9],
  input  logic [FACE_BITS-1:0]                  face_in,
  input  logic                                  first_in,
  input  logic signed [COORD_BITS-1:0]          org [3],
  input  logic signed [COORD_BITS-1:0]          dir [3],
  input  logic                                  cull,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_cand,
  output logic [rtn_pkg::PROD_BITS-1:0]         out_det,
  output logic [rtn_pkg::PROD_BITS-1:0]         out_tn,
  output logic [FACE_BITS-1:0]                  out_face,
  output logic                                  out_first
);

  localparam int PW = rtn_pkg::PROD_BITS;
  localparam int EW = COORD_BITS + 1;
  localparam int HW = EW + 1;
  localparam int MW = 2 * EW + 1;
  localparam int NS = 8;

  logic                 en;
  logic [NS-1:0]        vs;
  logic [FACE_BITS-1:0] fs [NS-1];
  logic                 qs [NS-1];
  logic signed [EW-1:0] e1 [3], e2 [3], s [3];
  logic signed [PW-1:0] pa [3], pb [3], qa [3], qb [3];
  logic signed [EW-1:0] e1b [3], e2b [3], sb [3];
  logic signed [PW-1:0] p [3], q [3];
  logic signed [EW-1:0] e1c [3], e2c [3], sc [3];
  logic signed [HW-1:0] ph [3], pl [3], qh [3], ql [3];
  logic signed [MW-1:0] dh [3], dl [3], uh [3], ul [3];
  logic signed [MW-1:0] vh [3], vl [3], th [3], tl [3];
  logic signed [PW-1:0] dm [3], um [3], vm [3], tm [3];
  logic signed [PW-1:0] det, un, vn, tn;
  logic signed [PW-1:0] dn, unn, vnn, tnn;
  logic                 rej, cand;

  // Each stage advances when the output stage is empty or being taken.
  assign en       = !vs[NS-1] || out_ready;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[NS-2:0], in_valid};
    end
  end

  // The cross products are split into high and low halves so that every
  // multiplier stays near the coordinate width.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ph[i] = p[i][2*EW:EW];
      pl[i] = {1'b0, p[i][EW-1:0]};
      qh[i] = q[i][2*EW:EW];
      ql[i] = {1'b0, q[i][EW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs[0] <= face_in;
      qs[0] <= first_in;
      for (int k = 1; k < NS - 1; k++) begin
        fs[k] <= fs[k-1];
        qs[k] <= qs[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EW'(vtx[3+i]) - EW'(vtx[i]);
        e2[i] <= EW'(vtx[6+i]) - EW'(vtx[i]);
        s[i]  <= EW'(org[i]) - EW'(vtx[i]);
      end
      for (int i = 0; i < 3; i++) begin
        pa[i] <= PW'(dir[(i+1)%3]) * PW'(e2[(i+2)%3]);
        pb[i] <= PW'(dir[(i+2)%3]) * PW'(e2[(i+1)%3]);
        qa[i] <= PW'(s[(i+1)%3]) * PW'(e1[(i+2)%3]);
        qb[i] <= PW'(s[(i+2)%3]) * PW'(e1[(i+1)%3]);
        e1b[i] <= e1[i];
        e2b[i] <= e2[i];
        sb[i]  <= s[i];
      end
      for (int i = 0; i < 3; i++) begin
        p[i]   <= pa[i] - pb[i];
        q[i]   <= qa[i] - qb[i];
        e1c[i] <= e1b[i];
        e2c[i] <= e2b[i];
        sc[i]  <= sb[i];
      end
      for (int i = 0; i < 3; i++) begin
        dh[i] <= MW'(e1c[i]) * MW'(ph[i]);
        dl[i] <= MW'(e1c[i]) * MW'(pl[i]);
        uh[i] <= MW'(sc[i]) * MW'(ph[i]);
        ul[i] <= MW'(sc[i]) * MW'(pl[i]);
        vh[i] <= MW'(dir[i]) * MW'(qh[i]);
        vl[i] <= MW'(dir[i]) * MW'(ql[i]);
        th[i] <= MW'(e2c[i]) * MW'(qh[i]);
        tl[i] <= MW'(e2c[i]) * MW'(ql[i]);
      end
      for (int i = 0; i < 3; i++) begin
        dm[i] <= (PW'(dh[i]) <<< EW) + PW'(dl[i]);
        um[i] <= (PW'(uh[i]) <<< EW) + PW'(ul[i]);
        vm[i] <= (PW'(vh[i]) <<< EW) + PW'(vl[i]);
        tm[i] <= (PW'(th[i]) <<< EW) + PW'(tl[i]);
      end
      det <= dm[0] + dm[1] + dm[2];
      un  <= um[0] + um[1] + um[2];
      vn  <= vm[0] + vm[1] + vm[2];
      tn  <= tm[0] + tm[1] + tm[2];
      if (cull) begin
        rej <= det[PW-1] || (det == '0);
      end else begin
        rej <= (det[PW-1] ? -det : det) < $signed(rtn_pkg::DET_EPS);
      end
      dn  <= det[PW-1] ? -det : det;
      unn <= det[PW-1] ? -un : un;
      vnn <= det[PW-1] ? -vn : vn;
      tnn <= det[PW-1] ? -tn : tn;
      out_cand  <= cand;
      out_det   <= dn;
      out_tn    <= tnn;
      out_face  <= fs[NS-2];
      out_first <= qs[NS-2];
    end
  end

  assign cand = !rej && !unn[PW-1] && !(dn < unn) && !vnn[PW-1] && !(dn < unn + vnn)
                && !tnn[PW-1] && (tnn != '0);

  assign out_valid = vs[NS-1];

endmodule

// ===== rtl/rtn_queue.sv =====
//------------------------------------------------------------------------------
// rtn_queue: short queue between front and back
// Two-entry register queue that decouples the front pipeline from the back.
//------------------------------------------------------------------------------
module rtn_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [rtn_pkg::QUEUE_DEPTH];
  logic             wp, rp;
  logic [1:0]       cnt;

  assign wr_ready = cnt != 2'(rtn_pkg::QUEUE_DEPTH);
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

endmodule

// ===== rtl/rtn_back.sv =====
//------------------------------------------------------------------------------
// rtn_back: distance divider and nearest-hit keeper
// Divides one quotient bit per cycle, compares against the running best and
// holds the result word until it is taken.
//------------------------------------------------------------------------------
module rtn_back #(
  parameter int FACE_BITS = rtn_pkg::FACE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cand,
  input  logic [rtn_pkg::PROD_BITS-1:0] in_det,
  input  logic [rtn_pkg::PROD_BITS-1:0] in_tn,
  input  logic [FACE_BITS-1:0]          in_face,
  input  logic                          in_first,
  input  logic [rtn_pkg::DIST_BITS-1:0] maxd,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          new_nearest,
  output logic                          any_hit,
  output logic [rtn_pkg::DIST_BITS-1:0] nearest_distance,
  output logic [FACE_BITS-1:0]          nearest_face
);

  localparam int PW = rtn_pkg::PROD_BITS;
  localparam int DW = rtn_pkg::DIST_BITS;

  rtn_pkg::back_state_t state, state_next;
  logic [PW-1:0]  rem, dv;
  logic [DW-1:0]  quo, best_distance, t;
  logic [FACE_BITS-1:0] face, best_face;
  logic [4:0]     bit_cnt;
  logic           cand, hit_found;
  logic [PW-1:0]  n0, trial;
  logic           take, fin;

  assign in_ready  = state == rtn_pkg::BK_IDLE;
  assign out_valid = state == rtn_pkg::BK_OUT;
  assign n0        = {in_tn[PW-13:0], 12'd0};
  assign trial     = rem >> bit_cnt;
  assign take      = !(trial < dv);
  assign fin       = bit_cnt == 5'd0;
  assign t         = quo | (take ? DW'(1) << bit_cnt : '0);

  always_comb begin
    state_next = state;
    case (state)
      rtn_pkg::BK_IDLE: if (in_valid) state_next = rtn_pkg::BK_DIV;
      rtn_pkg::BK_DIV:  if (!cand || fin) state_next = rtn_pkg::BK_OUT;
      rtn_pkg::BK_OUT:  if (!out_stall) state_next = rtn_pkg::BK_IDLE;
      default:          state_next = rtn_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rtn_pkg::BK_IDLE;
      best_distance <= '0;
      best_face     <= '0;
      hit_found     <= 1'b0;
      new_nearest   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        rtn_pkg::BK_IDLE: begin
          if (in_valid) begin
            rem     <= n0;
            dv      <= in_det;
            quo     <= '0;
            bit_cnt <= 5'd31;
            face    <= in_face;
            // Saturate when the quotient would not fit in 32 bits.
            cand    <= in_cand && ((n0 >> 32) < in_det);
            if (in_cand && !((n0 >> 32) < in_det)) quo <= '1;
            if (in_first) begin
              best_distance <= maxd;
              best_face     <= '0;
              hit_found     <= 1'b0;
            end
          end
        end
        rtn_pkg::BK_DIV: begin
          if (cand) begin
            if (take) rem <= rem - (dv << bit_cnt);
            quo     <= t;
            bit_cnt <= bit_cnt - 5'd1;
          end
          if (cand && !fin) begin
            new_nearest <= 1'b0;
          end else begin
            if (cand) begin
              new_nearest <= (t != '0) && (t < best_distance);
              if ((t != '0) && (t < best_distance)) begin
                best_distance <= t;
                best_face     <= face;
                hit_found     <= 1'b1;
              end
            end else begin
              new_nearest <= (quo != '0) && (quo < best_distance);
              if ((quo != '0) && (quo < best_distance)) begin
                best_distance <= quo;
                best_face     <= face;
                hit_found     <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign any_hit          = hit_found;
  assign nearest_distance = best_distance;
  assign nearest_face     = best_face;

endmodule

// ===== rtl/ray_triangle_nearest_hit_unit.sv =====
//------------------------------------------------------------------------------
// ray_triangle_nearest_hit_unit: ray against triangle nearest-hit unit
// A result word is offered once its triangle has passed the 8 front stages, the
// queue register and, on a candidate hit, the distance divider, which finds one
// quotient bit per cycle. The back end takes a new word only while idle, once the
// previous result has been taken, so output stalls hold back the queue and front.
// Synchronous reset clears the best hit and loads the register defaults.
//------------------------------------------------------------------------------
module ray_triangle_nearest_hit_unit #(
  parameter int COORD_BITS      = rtn_pkg::COORD_BITS_DEF,
  parameter int FACE_INDEX_BITS = rtn_pkg::FACE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtn_pkg::CFG_ADDR_BITS-1:0]  cfg_index,
  input  logic [rtn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       v0_x,
  input  logic signed [COORD_BITS-1:0]       v0_y,
  input  logic signed [COORD_BITS-1:0]       v0_z,
  input  logic signed [COORD_BITS-1:0]       v1_x,
  input  logic signed [COORD_BITS-1:0]       v1_y,
  input  logic signed [COORD_BITS-1:0]       v1_z,
  input  logic signed [COORD_BITS-1:0]       v2_x,
  input  logic signed [COORD_BITS-1:0]       v2_y,
  input  logic signed [COORD_BITS-1:0]       v2_z,
  input  logic [FACE_INDEX_BITS-1:0]         face_index,
  input  logic                               first_of_query,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               new_nearest,
  output logic                               any_hit,
  output logic [rtn_pkg::DIST_BITS-1:0]      nearest_distance,
  output logic [FACE_INDEX_BITS-1:0]         nearest_face
);

  localparam int PW = rtn_pkg::PROD_BITS;
  localparam int QW = 1 + PW + PW + FACE_INDEX_BITS + 1;

  logic signed [COORD_BITS-1:0] org [3], dir [3], vtx [9];
  logic [rtn_pkg::DIST_BITS-1:0] maxd;
  logic cull;
  logic f_valid, f_ready, f_cand, f_first;
  logic [PW-1:0] f_det, f_tn;
  logic [FACE_INDEX_BITS-1:0] f_face;
  logic [QW-1:0] q_out;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= COORD_BITS'(4096);
      maxd   <= '1;
      cull   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtn_pkg::REG_ORG_X: org[0] <= cfg_data[COORD_BITS-1:0];
        rtn_pkg::REG_ORG_Y: org[1] <= cfg_data[COORD_BITS-1:0];
        rtn_pkg::REG_ORG_Z: org[2] <= cfg_data[COORD_BITS-1:0];
        rtn_pkg::REG_DIR_X: dir[0] <= cfg_data[COORD_BITS-1:0];
        rtn_pkg::REG_DIR_Y: dir[1] <= cfg_data[COORD_BITS-1:0];
        rtn_pkg::REG_DIR_Z: dir[2] <= cfg_data[COORD_BITS-1:0];
        rtn_pkg::REG_MAXD:  maxd   <= cfg_data;
        rtn_pkg::REG_CULL:  cull   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign vtx[0] = v0_x;
  assign vtx[1] = v0_y;
  assign vtx[2] = v0_z;
  assign vtx[3] = v1_x;
  assign vtx[4] = v1_y;
  assign vtx[5] = v1_z;
  assign vtx[6] = v2_x;
  assign vtx[7] = v2_y;
  assign vtx[8] = v2_z;

  rtn_front #(.COORD_BITS(COORD_BITS), .FACE_BITS(FACE_INDEX_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .vtx, .face_in(face_index),
    .first_in(first_of_query), .org, .dir, .cull,
    .out_valid(f_valid), .out_ready(f_ready), .out_cand(f_cand),
    .out_det(f_det), .out_tn(f_tn), .out_face(f_face), .out_first(f_first)
  );

  rtn_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_cand, f_det, f_tn, f_face, f_first}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_out)
  );

  rtn_back #(.FACE_BITS(FACE_INDEX_BITS)) u_back (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready),
    .in_cand(q_out[QW-1]), .in_det(q_out[QW-2 -: PW]),
    .in_tn(q_out[QW-2-PW -: PW]), .in_face(q_out[FACE_INDEX_BITS:1]),
    .in_first(q_out[0]), .maxd, .out_valid, .out_stall,
    .new_nearest, .any_hit, .nearest_distance, .nearest_face
  );

endmodule
